// ----- hw/rtl/table_linear_interpolator_unit_macros.svh -----
// assertion helpers, sampled on clk and disabled during rst
`ifndef TABLE_LINEAR_INTERPOLATOR_UNIT_MACROS_SVH
`define TABLE_LINEAR_INTERPOLATOR_UNIT_MACROS_SVH

// same-cycle implication
`define TLI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TLI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/tli_pkg.sv -----
package tli_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

  // width of the unsigned product that the divider consumes
  localparam int DIV_W   = 32;
  localparam int DCNT_W  = $clog2(DIV_W);

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [2:0] STAT_INTERP = 3'd0;
  localparam logic [2:0] STAT_OK     = 3'd1;
  localparam logic [2:0] STAT_RANGE  = 3'd2;
  localparam logic [2:0] STAT_FULL   = 3'd3;
  localparam logic [2:0] STAT_EMPTY  = 3'd4;

  localparam logic signed [15:0] LIFT_MAX = 16'sh7fff;
  localparam logic signed [15:0] LIFT_MIN = 16'sh8000;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] angle_in;
    logic signed [15:0] lift_in;
  } tli_req_t;

  typedef struct packed {
    logic signed [15:0] lift_out;
    logic [2:0]         status;
  } tli_res_t;

endpackage

// ----- hw/rtl/table_linear_interpolator_unit.sv -----
// append, clear, unused commands: result on done in the cycle after the request, back to back.
// query: an empty table answers in the cycle after the request; else first and last entries
// are range-checked, then a scan of one entry per cycle finds an exact hit or the first entry
// above the query, interpolated via a 32-step restoring divide on one 18-bit adder;
// busy while a query runs, the next request is taken in the cycle its result is strobed.
// rst clears the entry count and control state; table contents stay undefined.
`include "table_linear_interpolator_unit_macros.svh"

module table_linear_interpolator_unit
  import tli_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  tli_req_t request,
  output logic     busy,
  output logic     done,
  output tli_res_t result
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_FIRST, ST_LAST, ST_SCAN, ST_DQ, ST_DEN, ST_DL, ST_ABS,
    ST_MUL, ST_DIV, ST_SUM
  } state_t;

  state_t state;

  logic signed [15:0] angle_table [TABLE_DEPTH];
  logic signed [15:0] lift_table  [TABLE_DEPTH];
  logic signed [15:0] angle_rd;
  logic signed [15:0] lift_rd;

  logic [COUNT_W-1:0] entry_count;
  logic [COUNT_W-1:0] cnt_m1;
  logic [ADDR_W-1:0]  last_addr;
  logic [ADDR_W-1:0]  idx;
  logic [ADDR_W-1:0]  rd_addr;
  logic               rd_en;
  logic               wr_en;
  logic               accept;
  logic               full;

  logic signed [15:0] q_angle;
  logic signed [15:0] prev_angle;
  logic signed [15:0] prev_lift;
  logic signed [15:0] hi_angle;
  logic signed [15:0] hi_lift;
  logic [15:0]        dq;
  logic [15:0]        den;
  logic signed [16:0] dl;
  logic               dl_neg;
  logic [15:0]        dl_mag;
  logic [DIV_W-1:0]   quot;
  logic [15:0]        rem;
  logic [DCNT_W-1:0]  div_cnt;

  // shared add/subtract unit
  logic signed [17:0] alu_a;
  logic signed [17:0] alu_b;
  logic               alu_sub;
  logic signed [17:0] alu_b_eff;
  logic signed [17:0] alu_res;
  logic               alu_neg;
  logic               alu_zero;

  function automatic logic signed [17:0] sx(input logic signed [15:0] v);
    return {{2{v[15]}}, v};
  endfunction

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign full      = (entry_count == COUNT_W'(TABLE_DEPTH));
  assign cnt_m1    = entry_count - 1'b1;
  assign last_addr = cnt_m1[ADDR_W-1:0];
  assign wr_en     = accept && (request.cmd == CMD_APPEND) && !full;

  assign alu_b_eff = alu_sub ? ~alu_b : alu_b;
  assign alu_res   = alu_a + alu_b_eff + {17'd0, alu_sub};
  assign alu_neg   = alu_res[17];
  assign alu_zero  = (alu_res == '0);

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    unique case (state)
      ST_FIRST: begin
        alu_a = sx(q_angle);
        alu_b = sx(angle_rd);
      end
      ST_LAST: begin
        alu_a = sx(angle_rd);
        alu_b = sx(q_angle);
      end
      ST_SCAN: begin
        alu_a = sx(q_angle);
        alu_b = sx(angle_rd);
      end
      ST_DQ: begin
        alu_a = sx(q_angle);
        alu_b = sx(prev_angle);
      end
      ST_DEN: begin
        alu_a = sx(hi_angle);
        alu_b = sx(prev_angle);
      end
      ST_DL: begin
        alu_a = sx(hi_lift);
        alu_b = sx(prev_lift);
      end
      ST_ABS: begin
        alu_b   = {dl[16], dl};
        alu_sub = dl_neg;
      end
      ST_DIV: begin
        // trial subtract of the divisor from the shifted partial remainder
        alu_a = {1'b0, rem, quot[DIV_W-1]};
        alu_b = {2'b00, den};
      end
      ST_SUM: begin
        alu_a   = sx(prev_lift);
        alu_b   = {2'b00, quot[15:0]};
        alu_sub = dl_neg;
      end
      default: begin
        alu_sub = 1'b1;
      end
    endcase
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (state)
      ST_IDLE: begin
        rd_en = accept && (request.cmd == CMD_QUERY);
      end
      ST_FIRST: begin
        rd_en   = 1'b1;
        rd_addr = last_addr;
      end
      ST_LAST: begin
        rd_en = 1'b1;
      end
      ST_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = idx + 1'b1;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      angle_table[entry_count[ADDR_W-1:0]] <= request.angle_in;
      lift_table[entry_count[ADDR_W-1:0]]  <= request.lift_in;
    end
    if (rd_en) begin
      angle_rd <= angle_table[rd_addr];
      lift_rd  <= lift_table[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      done        <= 1'b0;
      entry_count <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            q_angle <= request.angle_in;
            unique case (request.cmd)
              CMD_APPEND: begin
                done <= 1'b1;
                if (full) begin
                  result <= '{lift_out: '0, status: STAT_FULL};
                end else begin
                  entry_count <= entry_count + 1'b1;
                  result      <= '{lift_out: '0, status: STAT_OK};
                end
              end
              CMD_CLEAR: begin
                done        <= 1'b1;
                entry_count <= '0;
                result      <= '{lift_out: '0, status: STAT_OK};
              end
              CMD_QUERY: begin
                if (entry_count == '0) begin
                  done   <= 1'b1;
                  result <= '{lift_out: '0, status: STAT_EMPTY};
                end else begin
                  state <= ST_FIRST;
                end
              end
              default: begin
                done   <= 1'b1;
                result <= '{lift_out: '0, status: STAT_RANGE};
              end
            endcase
          end
        end
        ST_FIRST: begin
          if (alu_neg) begin
            done   <= 1'b1;
            result <= '{lift_out: '0, status: STAT_RANGE};
            state  <= ST_IDLE;
          end else begin
            state <= ST_LAST;
          end
        end
        ST_LAST: begin
          idx <= '0;
          if (alu_neg) begin
            done   <= 1'b1;
            result <= '{lift_out: '0, status: STAT_RANGE};
            state  <= ST_IDLE;
          end else begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (alu_zero) begin
            done   <= 1'b1;
            result <= '{lift_out: lift_rd, status: STAT_OK};
            state  <= ST_IDLE;
          end else if (alu_neg) begin
            // first entry above the query; the previous one is below it
            hi_angle <= angle_rd;
            hi_lift  <= lift_rd;
            state    <= ST_DQ;
          end else if (idx == last_addr) begin
            done   <= 1'b1;
            result <= '{lift_out: '0, status: STAT_RANGE};
            state  <= ST_IDLE;
          end else begin
            prev_angle <= angle_rd;
            prev_lift  <= lift_rd;
            idx        <= idx + 1'b1;
          end
        end
        ST_DQ: begin
          dq    <= alu_res[15:0];
          state <= ST_DEN;
        end
        ST_DEN: begin
          den   <= alu_res[15:0];
          state <= ST_DL;
        end
        ST_DL: begin
          dl     <= alu_res[16:0];
          dl_neg <= alu_neg;
          state  <= ST_ABS;
        end
        ST_ABS: begin
          dl_mag <= alu_res[15:0];
          state  <= ST_MUL;
        end
        ST_MUL: begin
          quot    <= dq * dl_mag;
          rem     <= '0;
          div_cnt <= DCNT_W'(DIV_W - 1);
          state   <= ST_DIV;
        end
        ST_DIV: begin
          if (!alu_neg) begin
            rem  <= alu_res[15:0];
            quot <= {quot[DIV_W-2:0], 1'b1};
          end else begin
            rem  <= {rem[14:0], quot[DIV_W-1]};
            quot <= {quot[DIV_W-2:0], 1'b0};
          end
          if (div_cnt == '0) begin
            state <= ST_SUM;
          end else begin
            div_cnt <= div_cnt - 1'b1;
          end
        end
        ST_SUM: begin
          done  <= 1'b1;
          state <= ST_IDLE;
          if (alu_res[17:15] == 3'b000 || alu_res[17:15] == 3'b111) begin
            result <= '{lift_out: alu_res[15:0], status: STAT_INTERP};
          end else if (alu_neg) begin
            result <= '{lift_out: LIFT_MIN, status: STAT_INTERP};
          end else begin
            result <= '{lift_out: LIFT_MAX, status: STAT_INTERP};
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `TLI_ASSERT_NEXT(a_short_cmd_done,
    accept && !(request.cmd == CMD_QUERY && entry_count != '0), done && !busy,
    "request without table walk did not finish in one cycle")
  `TLI_ASSERT_NEXT(a_query_busy,
    accept && request.cmd == CMD_QUERY && entry_count != '0, busy && !done,
    "query on a filled table did not start the walk")
  `TLI_ASSERT_NOW(a_zero_lift,
    done && result.status != STAT_INTERP && result.status != STAT_OK,
    result.lift_out == '0, "nonzero lift with an error status")
  `TLI_ASSERT_NOW(a_count_bound, 1'b1, entry_count <= COUNT_W'(TABLE_DEPTH),
    "entry count beyond table depth")
  `TLI_ASSERT_NOW(a_div_nonzero, state == ST_DIV, den != '0,
    "divide started with a zero angle span")

endmodule
